>>> sv/tssf_pkg.sv
// shared types and constants of the transport segment state machine
`timescale 1ns / 1ps
`default_nettype none

package tssf_pkg;

   localparam int NUM_ENTRIES = 4;
   localparam int IDX_W       = 2;
   localparam int PORT_W      = 16;
   localparam int SEQ_W       = 32;
   localparam int LEN_W       = 11;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 16;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_LOCAL_PORT_A = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOCAL_PORT_B = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LOCAL_PORT_C = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LOCAL_PORT_D = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LISTEN_MASK  = 3'd4;

   typedef enum logic [1:0] {
      SEG_SYN   = 2'd0,
      SEG_FIN   = 2'd1,
      SEG_DATA  = 2'd2,
      SEG_OTHER = 2'd3
   } seg_kind_type;

   typedef enum logic [1:0] {
      ACK_SYN  = 2'd0,
      ACK_FIN  = 2'd1,
      ACK_DATA = 2'd2
   } ack_kind_type;

   typedef enum logic [1:0] {
      PHASE_IDLE       = 2'd0,
      PHASE_CONNECTED  = 2'd1,
      PHASE_CLOSE_WAIT = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_SCAN = 2'd1,
      ST_EXEC = 2'd2
   } seq_state_type;

   typedef logic [NUM_ENTRIES-1:0][PORT_W-1:0] port_array_type;

   typedef struct packed {
      logic             done;
      logic             found;
      logic [IDX_W-1:0] index;
   } match_result_type;

   typedef struct packed {
      phase_type         phase;
      logic [PORT_W-1:0] peer;
      logic [SEQ_W-1:0]  expected;
   } entry_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] index;
      entry_type        entry;
   } entry_write_type;

endpackage

`default_nettype wire

>>> sv/tssf_match.sv
// port match scanner: one comparator visits one connection entry per cycle
`timescale 1ns / 1ps
`default_nettype none

module tssf_match
   import tssf_pkg::*;
#(
   parameter int LIMIT = 4
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [PORT_W-1:0] dport,
   input  wire port_array_type    local_ports,
   input  wire logic [NUM_ENTRIES-1:0] enable_mask,
   output match_result_type       result
);

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LIMIT - 1);

   logic             busy_ff;
   logic [IDX_W-1:0] idx_ff;
   logic             hit;
   logic             last;

   // the shared 16-bit compare
   assign hit  = busy_ff && enable_mask[idx_ff] && (local_ports[idx_ff] == dport);
   assign last = (idx_ff == LAST_IDX);

   assign result.done  = busy_ff && (hit || last);
   assign result.found = hit;
   assign result.index = idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         idx_ff  <= '0;
      end else if (busy_ff) begin
         if (result.done) begin
            busy_ff <= 1'b0;
         end else begin
            idx_ff <= idx_ff + 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

>>> sv/tssf_conn_table.sv
// per-entry connection state: phase, peer port and expected sequence
`timescale 1ns / 1ps
`default_nettype none

module tssf_conn_table
   import tssf_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic [IDX_W-1:0]       rd_index,
   output entry_type                   rd_entry,
   input  wire entry_write_type        wr,
   input  wire logic [NUM_ENTRIES-1:0] close_mask
);

   entry_type entry_ff [NUM_ENTRIES];

   assign rd_entry = entry_ff[rd_index];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_ENTRIES; i++) begin
            entry_ff[i] <= '0;
         end
      end else begin
         if (wr.en) begin
            entry_ff[wr.index] <= wr.entry;
         end
         // a closed entry reopens as a fresh listener, peer and sequence kept
         for (int i = 0; i < NUM_ENTRIES; i++) begin
            if (close_mask[i]) begin
               entry_ff[i].phase <= PHASE_IDLE;
            end
         end
      end
   end

endmodule

`default_nettype wire

>>> sv/transport_server_segment_fsm.sv
// transport server segment state machine, top level
//
// usage: segment headers arrive on the req_ channel (valid/stall), one
// acknowledgement or none leaves per request on the rsp_ channel. the four
// local ports and the listen enable mask are written over the csr_ port; the
// user must do so only while the block is idle, which the block does not enforce.
// a request with a bad checksum is dropped as it is taken. otherwise the
// scanner compares one entry per cycle against the destination port,
// stopping at the first enabled match or at the last entry taking part,
// then the execute step runs the entry's state machine and loads the
// result register. a request with no enabled match ends after the scan;
// the result shows on rsp_valid in the cycle after the execute step. the
// scan time is set by the single port comparator in the scanner.
// req_stall is low only while the sequencer is idle; the result register
// lets a new request enter while the previous acknowledgement waits.
// when rsp_stall holds the result register full, the execute step waits
// and no entry state changes until the register frees up.
// reset clears the configuration and sequencer registers, entry state and the output valid flag.
`timescale 1ns / 1ps
`default_nettype none

module transport_server_segment_fsm
   import tssf_pkg::*;
#(
   parameter int NUM_CONNECTIONS = 4,
   parameter int MAX_PAYLOAD     = 1024
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request channel
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic                  req_checksum_good,
   input  wire logic [1:0]            req_seg_type,
   input  wire logic [PORT_W-1:0]     req_source_port,
   input  wire logic [PORT_W-1:0]     req_destination_port,
   input  wire logic [SEQ_W-1:0]      req_sequence_number,
   input  wire logic [LEN_W-1:0]      req_payload_length,
   // result channel
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [1:0]                 rsp_ack_kind,
   output logic [PORT_W-1:0]          rsp_ack_source_port,
   output logic [PORT_W-1:0]          rsp_ack_destination_port,
   output logic [SEQ_W-1:0]           rsp_ack_number,
   output logic [IDX_W-1:0]           rsp_entry_index,
   output logic                       rsp_payload_accepted,
   // configuration port
   input  wire logic                  csr_write_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   // entries beyond the four with port registers never take part
   localparam int LIMIT = (NUM_CONNECTIONS < NUM_ENTRIES) ? NUM_CONNECTIONS : NUM_ENTRIES;
   localparam logic [16:0] MAX_LEN = 17'(MAX_PAYLOAD);

   // configuration registers
   port_array_type         local_port_ff;
   logic [NUM_ENTRIES-1:0] listen_mask_ff;
   logic [NUM_ENTRIES-1:0] close_mask;

   // captured request
   seg_kind_type      seg_ff;
   logic [PORT_W-1:0] sport_ff;
   logic [PORT_W-1:0] dport_ff;
   logic [SEQ_W-1:0]  seq_ff;
   logic [LEN_W-1:0]  len_ff;
   logic [IDX_W-1:0]  ent_ff;

   // sequencer
   seq_state_type    state_ff;
   seq_state_type    state_in;
   logic             req_accept;
   logic             scan_start;
   match_result_type match;

   // entry table access
   entry_type       cur;
   entry_write_type wr;

   // execute step decision
   logic             out_free;
   logic             emit;
   ack_kind_type     kind;
   logic [PORT_W-1:0] ack_sport;
   logic [PORT_W-1:0] ack_dport;
   logic [SEQ_W-1:0]  ack_num;
   logic              acc;
   logic              seq_match;
   logic [SEQ_W-1:0]  exp_sum;
   logic              len_ok;

   // result register
   logic              rsp_valid_ff;
   ack_kind_type      rsp_kind_ff;
   logic [PORT_W-1:0] rsp_sport_ff;
   logic [PORT_W-1:0] rsp_dport_ff;
   logic [SEQ_W-1:0]  rsp_num_ff;
   logic [IDX_W-1:0]  rsp_idx_ff;
   logic              rsp_acc_ff;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign scan_start = req_accept && req_checksum_good;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // configuration writes
   always_comb begin
      close_mask = '0;
      if (csr_write_en && (csr_index == CSR_LISTEN_MASK)) begin
         close_mask = listen_mask_ff & ~csr_data[NUM_ENTRIES-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         local_port_ff  <= '0;
         listen_mask_ff <= '0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_LOCAL_PORT_A: local_port_ff[0] <= csr_data;
            CSR_LOCAL_PORT_B: local_port_ff[1] <= csr_data;
            CSR_LOCAL_PORT_C: local_port_ff[2] <= csr_data;
            CSR_LOCAL_PORT_D: local_port_ff[3] <= csr_data;
            CSR_LISTEN_MASK:  listen_mask_ff   <= csr_data[NUM_ENTRIES-1:0];
            default: ;  // unknown index, write ignored
         endcase
      end
   end

   // port match scanner
   tssf_match #(
      .LIMIT(LIMIT)
   ) u_match (
      .clock      (clock),
      .reset      (reset),
      .start      (scan_start),
      .dport      (dport_ff),
      .local_ports(local_port_ff),
      .enable_mask(listen_mask_ff),
      .result     (match)
   );

   // connection state table
   tssf_conn_table u_table (
      .clock     (clock),
      .reset     (reset),
      .rd_index  (ent_ff),
      .rd_entry  (cur),
      .wr        (wr),
      .close_mask(close_mask)
   );

   // request capture and matched entry
   always_ff @(posedge clock) begin
      if (req_accept) begin
         seg_ff   <= seg_kind_type'(req_seg_type);
         sport_ff <= req_source_port;
         dport_ff <= req_destination_port;
         seq_ff   <= req_sequence_number;
         len_ff   <= req_payload_length;
      end
      if (state_ff == ST_SCAN && match.done) begin
         ent_ff <= match.index;
      end
   end

   // the shared 32-bit compare and add of the execute step
   assign seq_match = (seq_ff == cur.expected);
   assign exp_sum   = cur.expected + SEQ_W'(len_ff);
   assign len_ok    = (17'(len_ff) <= MAX_LEN);

   // entry state machine; matched local port equals the held destination port
   always_comb begin
      emit      = 1'b0;
      kind      = ACK_SYN;
      ack_sport = dport_ff;
      ack_dport = cur.peer;
      ack_num   = cur.expected;
      acc       = 1'b0;
      wr.en     = 1'b0;
      wr.index  = ent_ff;
      wr.entry  = cur;
      unique case (cur.phase)
         PHASE_IDLE, PHASE_CONNECTED: begin
            if (seg_ff == SEG_SYN) begin
               // open or restart the connection
               emit              = 1'b1;
               kind              = ACK_SYN;
               ack_dport         = sport_ff;
               ack_num           = seq_ff;
               wr.en             = 1'b1;
               wr.entry.phase    = PHASE_CONNECTED;
               wr.entry.peer     = sport_ff;
               wr.entry.expected = seq_ff;
            end else if (cur.phase == PHASE_CONNECTED) begin
               if (seg_ff == SEG_FIN && seq_match) begin
                  emit           = 1'b1;
                  kind           = ACK_FIN;
                  wr.en          = 1'b1;
                  wr.entry.phase = PHASE_CLOSE_WAIT;
               end else if (seg_ff == SEG_DATA && len_ok) begin
                  emit = 1'b1;
                  kind = ACK_DATA;
                  if (seq_match) begin
                     ack_num           = exp_sum;
                     acc               = 1'b1;
                     wr.en             = 1'b1;
                     wr.entry.expected = exp_sum;
                  end else begin
                     // out of order: echo the segment's ports swapped
                     ack_dport = sport_ff;
                  end
               end
            end
         end
         PHASE_CLOSE_WAIT: begin
            if (seg_ff == SEG_FIN) begin
               emit = 1'b1;
               kind = ACK_FIN;
            end
         end
         default: ;  // unused phase, segment ignored
      endcase
      // nothing changes until the result register can take the result
      if (state_ff != ST_EXEC || !out_free) begin
         emit  = 1'b0;
         wr.en = 1'b0;
      end
   end

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (scan_start) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (match.done) begin
               state_in = match.found ? ST_EXEC : ST_IDLE;
            end
         end
         ST_EXEC: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_kind_ff  <= kind;
         rsp_sport_ff <= ack_sport;
         rsp_dport_ff <= ack_dport;
         rsp_num_ff   <= ack_num;
         rsp_idx_ff   <= ent_ff;
         rsp_acc_ff   <= acc;
      end
   end

   assign rsp_valid                = rsp_valid_ff;
   assign rsp_ack_kind             = rsp_kind_ff;
   assign rsp_ack_source_port      = rsp_sport_ff;
   assign rsp_ack_destination_port = rsp_dport_ff;
   assign rsp_ack_number           = rsp_num_ff;
   assign rsp_entry_index          = rsp_idx_ff;
   assign rsp_payload_accepted     = rsp_acc_ff;

endmodule

`default_nettype wire

>>> tb/sv/transport_server_segment_fsm_tb.sv
// self-checking testbench of the transport server segment state machine
`timescale 1ns / 1ps

module transport_server_segment_fsm_tb;
   import tssf_pkg::*;

   localparam int CLK_PERIOD   = 12;
   localparam int MAX_LEN      = 1024;
   localparam int SESSION_GOAL = 2000;   // random session requests to send, noise not counted
   localparam int PHASE_GOAL   = 200;    // requests between two register settings
   localparam int DRAIN_CYCLES = 24;     // worst item latency plus a full output stall
   localparam int CYCLE_LIMIT  = 500000;

   // index with no register behind it, writes there must be ignored
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 3'd7;

   typedef struct {
      logic              checksum_good;
      seg_kind_type      seg;
      logic [PORT_W-1:0] src;
      logic [PORT_W-1:0] dst;
      logic [SEQ_W-1:0]  seq;
      logic [LEN_W-1:0]  len;
   } segment_type;

   typedef struct {
      ack_kind_type      kind;
      logic [PORT_W-1:0] src;
      logic [PORT_W-1:0] dst;
      logic [SEQ_W-1:0]  number;
      logic [IDX_W-1:0]  index;
      logic              accepted;
   } ack_type;

   // clock, reset and block ports, inputs known from time zero
   logic                  clock        = 1'b0;
   logic                  reset        = 1'b1;
   logic                  req_valid    = 1'b0;
   logic                  req_stall;
   logic                  rsp_valid;
   logic                  rsp_stall    = 1'b0;
   logic [1:0]            rsp_ack_kind;
   logic [PORT_W-1:0]     rsp_ack_source_port;
   logic [PORT_W-1:0]     rsp_ack_destination_port;
   logic [SEQ_W-1:0]      rsp_ack_number;
   logic [IDX_W-1:0]      rsp_entry_index;
   logic                  rsp_payload_accepted;
   logic                  csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index    = '0;
   logic [CSR_DATA_W-1:0] csr_data     = '0;

   // request currently on the input ports
   segment_type req_now = '{1'b0, SEG_SYN, '0, '0, '0, '0};

   // own copy of the connection table and its registers
   logic [PORT_W-1:0]      table_port     [NUM_ENTRIES];
   logic [NUM_ENTRIES-1:0] table_mask;
   phase_type              table_phase    [NUM_ENTRIES];
   logic [PORT_W-1:0]      table_peer     [NUM_ENTRIES];
   logic [SEQ_W-1:0]       table_expected [NUM_ENTRIES];

   segment_type segments_to_send[$];
   ack_type     acks_due[$];

   int  errors         = 0;
   int  cycle_count    = 0;
   int  requests_taken = 0;
   int  acks_checked   = 0;
   int  csr_writes     = 0;
   int  req_gap        = 0;
   int  rsp_hold       = 0;
   bit  req_taken      = 1'b0;
   bit  req_steady     = 1'b0;   // stretches with no gaps between requests
   bit  rsp_steady     = 1'b0;   // stretches with no output stall

   transport_server_segment_fsm DUT (
      .clock                    (clock),
      .reset                    (reset),
      .req_valid                (req_valid),
      .req_stall                (req_stall),
      .req_checksum_good        (req_now.checksum_good),
      .req_seg_type             (req_now.seg),
      .req_source_port          (req_now.src),
      .req_destination_port     (req_now.dst),
      .req_sequence_number      (req_now.seq),
      .req_payload_length       (req_now.len),
      .rsp_valid                (rsp_valid),
      .rsp_stall                (rsp_stall),
      .rsp_ack_kind             (rsp_ack_kind),
      .rsp_ack_source_port      (rsp_ack_source_port),
      .rsp_ack_destination_port (rsp_ack_destination_port),
      .rsp_ack_number           (rsp_ack_number),
      .rsp_entry_index          (rsp_entry_index),
      .rsp_payload_accepted     (rsp_payload_accepted),
      .csr_write_en             (csr_write_en),
      .csr_index                (csr_index),
      .csr_data                 (csr_data)
   );

   initial begin
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   // ---------------------------------------------------------------
   // connection table model
   // ---------------------------------------------------------------

   function automatic void apply_csr(input logic [CSR_IDX_W-1:0] idx,
                                     input logic [CSR_DATA_W-1:0] data);
      int i;
      case (idx)
         CSR_LOCAL_PORT_A: table_port[0] = data;
         CSR_LOCAL_PORT_B: table_port[1] = data;
         CSR_LOCAL_PORT_C: table_port[2] = data;
         CSR_LOCAL_PORT_D: table_port[3] = data;
         CSR_LISTEN_MASK: begin
            // closing an entry drops it back to a fresh listener, peer and
            // sequence survive
            for (i = 0; i < NUM_ENTRIES; i++)
               if (table_mask[i] && !data[i]) table_phase[i] = PHASE_IDLE;
            table_mask = data[NUM_ENTRIES-1:0];
         end
         default: ;
      endcase
   endfunction

   // runs one segment through the table, returns 1 when it is acknowledged
   function automatic bit handle_segment(input segment_type s, output ack_type a);
      int e;
      int i;
      e = -1;
      a.kind     = ACK_SYN;
      a.accepted = 1'b0;
      if (!s.checksum_good) return 0;
      // lowest enabled entry with the destination port wins
      for (i = 0; i < NUM_ENTRIES; i++)
         if (e < 0 && table_mask[i] && table_port[i] == s.dst) e = i;
      if (e < 0) return 0;
      a.index = e[IDX_W-1:0];
      a.src   = table_port[e];
      case (table_phase[e])
         PHASE_IDLE, PHASE_CONNECTED: begin
            if (s.seg == SEG_SYN) begin
               // fresh open or restart of a live connection
               table_peer[e]     = s.src;
               table_expected[e] = s.seq;
               table_phase[e]    = PHASE_CONNECTED;
               a.kind            = ACK_SYN;
            end else if (table_phase[e] != PHASE_CONNECTED) begin
               return 0;
            end else if (s.seg == SEG_FIN) begin
               if (s.seq != table_expected[e]) return 0;
               table_phase[e] = PHASE_CLOSE_WAIT;
               a.kind         = ACK_FIN;
            end else if (s.seg == SEG_DATA) begin
               if (s.len > MAX_LEN) return 0;
               a.kind = ACK_DATA;
               if (s.seq == table_expected[e]) begin
                  table_expected[e] = table_expected[e] + SEQ_W'(s.len);
                  a.accepted        = 1'b1;
               end else begin
                  // out of order: ports of the segment swapped
                  a.src    = s.dst;
                  a.dst    = s.src;
                  a.number = table_expected[e];
                  return 1;
               end
            end else begin
               return 0;
            end
         end
         PHASE_CLOSE_WAIT: begin
            if (s.seg != SEG_FIN) return 0;
            a.kind = ACK_FIN;
         end
         default: return 0;
      endcase
      a.dst    = table_peer[e];
      a.number = table_expected[e];
      return 1;
   endfunction

   // ---------------------------------------------------------------
   // request driver
   // ---------------------------------------------------------------

   function automatic int idle_draw(input bit steady);
      return steady ? 0 : $urandom_range(0, 5);
   endfunction

   // note each accepted request and predict its acknowledgement
   always @(posedge clock) begin
      ack_type ack;
      if (!reset && req_valid && !req_stall) begin
         if (handle_segment(req_now, ack)) acks_due.push_back(ack);
         requests_taken++;
         req_taken = 1'b1;
         if ($urandom_range(0, 49) == 0) req_steady = !req_steady;
      end
   end

   // present the next request at the falling edge, valid set only once
   always @(negedge clock) begin
      logic next_valid;
      next_valid = req_valid;
      if (req_taken) begin
         req_taken  = 1'b0;
         next_valid = 1'b0;
         req_gap    = idle_draw(req_steady);
      end
      if (!reset && !next_valid) begin
         if (req_gap > 0) begin
            req_gap--;
         end else if (segments_to_send.size() > 0) begin
            req_now    = segments_to_send.pop_front();
            next_valid = 1'b1;
         end
      end
      req_valid <= next_valid;
   end

   // ---------------------------------------------------------------
   // acknowledgement monitor
   // ---------------------------------------------------------------

   // output stall, a fresh hold drawn after every acknowledgement
   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_stall <= 1'b1;
         rsp_hold--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      ack_type want;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d acknowledgements outstanding",
                  cycle_count, acks_due.size());
         $display("end of test: mismatches");
         $finish;
      end else if (!reset && rsp_valid && !rsp_stall) begin
         rsp_hold = idle_draw(rsp_steady);
         if ($urandom_range(0, 49) == 0) rsp_steady = !rsp_steady;
         if (acks_due.size() == 0) begin
            $display("%0t ns: unexpected acknowledgement, expected none, got kind %0d entry %0d",
                     $time, rsp_ack_kind, rsp_entry_index);
            errors++;
         end else begin
            want = acks_due.pop_front();
            acks_checked++;
            check_field("ack_kind", 32'(want.kind), 32'(rsp_ack_kind));
            check_field("ack_source_port", 32'(want.src), 32'(rsp_ack_source_port));
            check_field("ack_destination_port", 32'(want.dst),
                        32'(rsp_ack_destination_port));
            check_field("ack_number", want.number, rsp_ack_number);
            check_field("entry_index", 32'(want.index), 32'(rsp_entry_index));
            check_field("payload_accepted", 32'(want.accepted), 32'(rsp_payload_accepted));
         end
      end
   end

   // ---------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_write_en = 1'b1;
      csr_index    = idx;
      csr_data     = data;
      apply_csr(idx, data);
      csr_writes++;
      @(negedge clock);
      csr_write_en = 1'b0;
   endtask

   // mask write with junk in the unused upper bits
   task automatic write_mask(input logic [NUM_ENTRIES-1:0] mask);
      logic [CSR_DATA_W-1:0] data;
      data = CSR_DATA_W'($urandom);
      data[NUM_ENTRIES-1:0] = mask;
      write_csr(CSR_LISTEN_MASK, data);
   endtask

   // nothing queued, nothing on the wire, nothing due, then a quiet stretch
   task automatic wait_idle();
      int quiet;
      quiet = 0;
      while (quiet < DRAIN_CYCLES) begin
         @(negedge clock);
         if (segments_to_send.size() == 0 && !req_valid && !req_taken &&
             acks_due.size() == 0)
            quiet++;
         else
            quiet = 0;
      end
   endtask

   function automatic void push_segment(input logic good, input seg_kind_type kind,
                                        input logic [PORT_W-1:0] src,
                                        input logic [PORT_W-1:0] dst,
                                        input logic [SEQ_W-1:0] seq,
                                        input logic [LEN_W-1:0] len);
      segment_type s;
      s.checksum_good = good;
      s.seg           = kind;
      s.src           = src;
      s.dst           = dst;
      s.seq           = seq;
      s.len           = len;
      segments_to_send.push_back(s);
   endfunction

   function automatic logic [LEN_W-1:0] pick_len();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return LEN_W'(MAX_LEN);
         default: return LEN_W'($urandom_range(1, MAX_LEN - 1));
      endcase
   endfunction

   function automatic logic [PORT_W-1:0] pick_port();
      case ($urandom_range(0, 4))
         0:       return '0;
         1:       return '1;
         2:       return table_port[$urandom_range(0, NUM_ENTRIES - 1)];  // duplicate
         default: return PORT_W'($urandom);
      endcase
   endfunction

   // one connection: open, some data, usually a close; returns request count
   function automatic int add_session(input logic [PORT_W-1:0] port);
      logic [PORT_W-1:0] peer;
      logic [SEQ_W-1:0]  next_seq;
      logic [LEN_W-1:0]  len;
      int                count;
      bit                closed;
      peer     = PORT_W'($urandom);
      next_seq = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 2048)
                                             : $urandom;
      count    = 1;
      closed   = 1'b0;
      push_segment(1'b1, SEG_SYN, peer, port, next_seq, LEN_W'($urandom_range(0, 2047)));
      repeat ($urandom_range(0, 8)) begin
         count++;
         case ($urandom_range(0, 9))
            0: push_segment(1'b1, SEG_DATA, peer, port,
                            next_seq + $urandom_range(1, 32'hFFFF_FFFF), pick_len());
            1: push_segment(1'b1, SEG_DATA, peer, port, next_seq,
                            LEN_W'($urandom_range(MAX_LEN + 1, 2047)));
            2: push_segment(1'b0, SEG_DATA, peer, port, next_seq, pick_len());
            default: begin
               len = pick_len();
               push_segment(1'b1, SEG_DATA, peer, port, next_seq, len);
               next_seq = next_seq + SEQ_W'(len);
            end
         endcase
      end
      case ($urandom_range(0, 5))
         0: ;   // left open, a later open restarts it
         1: begin
            push_segment(1'b1, SEG_FIN, peer, port,
                         next_seq + $urandom_range(1, 32'hFFFF_FFFF), '0);
            push_segment(1'b1, SEG_FIN, peer, port, next_seq, '0);
            count += 2;
            closed = 1'b1;
         end
         default: begin
            push_segment(1'b1, SEG_FIN, peer, port, next_seq,
                         LEN_W'($urandom_range(0, 2047)));
            count++;
            closed = 1'b1;
         end
      endcase
      // repeated close and stray traffic while waiting to close
      if (closed && $urandom_range(0, 2) == 0) begin
         push_segment(1'b1, SEG_FIN, peer, port, $urandom, '0);
         push_segment(1'b1, seg_kind_type'($urandom_range(0, 3)), peer, port,
                      next_seq, pick_len());
         count += 2;
      end
      return count;
   endfunction

   function automatic void add_noise();
      logic [PORT_W-1:0] dst;
      dst = ($urandom_range(0, 1) == 0) ? table_port[$urandom_range(0, NUM_ENTRIES - 1)]
                                        : PORT_W'($urandom);
      push_segment(1'($urandom_range(0, 1)), seg_kind_type'($urandom_range(0, 3)),
                   PORT_W'($urandom), dst, $urandom, LEN_W'($urandom_range(0, 2047)));
   endfunction

   task automatic random_config();
      if ($urandom_range(0, 1) == 0) write_csr(CSR_LOCAL_PORT_A, pick_port());
      if ($urandom_range(0, 1) == 0) write_csr(CSR_LOCAL_PORT_B, pick_port());
      if ($urandom_range(0, 1) == 0) write_csr(CSR_LOCAL_PORT_C, pick_port());
      if ($urandom_range(0, 1) == 0) write_csr(CSR_LOCAL_PORT_D, pick_port());
      if ($urandom_range(0, 3) == 0) write_csr(CSR_UNUSED, CSR_DATA_W'($urandom));
      write_mask(($urandom_range(0, 3) == 0) ? 4'hF : NUM_ENTRIES'($urandom_range(0, 15)));
   endtask

   initial begin
      int i;
      int session_items;
      int phase_items;
      int phases;

      for (i = 0; i < NUM_ENTRIES; i++) begin
         table_port[i]     = '0;
         table_phase[i]    = PHASE_IDLE;
         table_peer[i]     = '0;
         table_expected[i] = '0;
      end
      table_mask = '0;

      // synchronous reset, released at a falling edge
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: entry three shares a port with entry zero, so it only
      // answers once entry zero is closed
      write_csr(CSR_LOCAL_PORT_A, 16'h0050);
      write_csr(CSR_LOCAL_PORT_B, 16'hFFFF);
      write_csr(CSR_LOCAL_PORT_C, 16'h0000);
      write_csr(CSR_LOCAL_PORT_D, 16'h0050);
      write_csr(CSR_UNUSED, 16'hFFFF);
      write_mask(4'hF);

      push_segment(1'b0, SEG_SYN,   16'h1234, 16'h0050, 32'h0000_0000, 11'd0);
      push_segment(1'b1, SEG_SYN,   16'h1234, 16'h0050, 32'hFFFF_FFF0, 11'd7);
      push_segment(1'b1, SEG_DATA,  16'h1234, 16'h0050, 32'hFFFF_FFF0, 11'd32);   // wraps
      push_segment(1'b1, SEG_DATA,  16'h1234, 16'h0050, 32'h0000_0005, 11'd10);   // out of order
      push_segment(1'b1, SEG_DATA,  16'h1234, 16'h0050, 32'h0000_0010, 11'd1025); // oversized
      push_segment(1'b1, SEG_DATA,  16'h1234, 16'h0050, 32'h0000_0010, 11'd2047);
      push_segment(1'b1, SEG_DATA,  16'h1234, 16'h0050, 32'h0000_0010, 11'd1024);
      push_segment(1'b1, SEG_DATA,  16'h1234, 16'h0050, 32'h0000_0410, 11'd0);
      push_segment(1'b1, SEG_OTHER, 16'h1234, 16'h0050, 32'h0000_0410, 11'd4);
      push_segment(1'b1, SEG_FIN,   16'h1234, 16'h0050, 32'h0000_0000, 11'd0);    // wrong seq
      push_segment(1'b1, SEG_FIN,   16'h1234, 16'h0050, 32'h0000_0410, 11'd0);
      push_segment(1'b1, SEG_FIN,   16'h1234, 16'h0050, 32'hFFFF_FFFF, 11'd0);    // close-wait
      push_segment(1'b1, SEG_DATA,  16'h1234, 16'h0050, 32'h0000_0410, 11'd4);
      push_segment(1'b1, SEG_SYN,   16'h1234, 16'h0050, 32'h0000_0001, 11'd0);
      push_segment(1'b1, SEG_SYN,   16'h1234, 16'h1235, 32'h0000_0001, 11'd0);    // no entry
      push_segment(1'b1, SEG_SYN,   16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 11'd2047);
      push_segment(1'b1, SEG_FIN,   16'h0000, 16'h0000, 32'h0000_0000, 11'd0);    // idle entry
      push_segment(1'b1, SEG_DATA,  16'h0000, 16'h0000, 32'h0000_0000, 11'd1);
      push_segment(1'b1, SEG_SYN,   16'h0000, 16'h0000, 32'h0000_0000, 11'd0);
      push_segment(1'b1, SEG_SYN,   16'h0001, 16'hFFFF, 32'h8000_0000, 11'd0);    // restart
      wait_idle();

      // closing entry zero hands its port to entry three
      write_mask(4'hE);
      push_segment(1'b1, SEG_SYN,  16'h4321, 16'h0050, 32'h0000_0055, 11'd0);
      wait_idle();

      // reopened entry zero listens again with old peer and sequence kept
      write_mask(4'hF);
      push_segment(1'b1, SEG_DATA, 16'h1234, 16'h0050, 32'h0000_0410, 11'd8);
      push_segment(1'b1, SEG_SYN,  16'h7777, 16'h0050, 32'h0000_0099, 11'd0);
      wait_idle();

      // everything closed
      write_mask(4'h0);
      push_segment(1'b1, SEG_SYN,  16'h1234, 16'h0050, 32'h0000_0000, 11'd0);
      wait_idle();

      // random: mostly whole connections, some noise, new setting per phase
      session_items = 0;
      phases        = 0;
      while (session_items < SESSION_GOAL) begin
         random_config();
         phases++;
         phase_items = 0;
         while (phase_items < PHASE_GOAL) begin
            if ($urandom_range(0, 4) == 0) begin
               add_noise();
            end else begin
               phase_items += add_session(($urandom_range(0, 7) == 0)
                  ? PORT_W'($urandom)
                  : table_port[$urandom_range(0, NUM_ENTRIES - 1)]);
            end
         end
         session_items += phase_items;
         wait_idle();
      end

      $display("%0d requests in, %0d acknowledgements checked over %0d random settings",
               requests_taken, acks_checked, phases);
      $display("%0d register writes, both channels idled and stalled at random", csr_writes);
      if (errors == 0 && acks_due.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
